// File: rtl/core/frd_pkg.sv
package frd_pkg;

  localparam int unsigned CosFracBits = 14;
  localparam int unsigned FieldW      = 16;
  localparam int unsigned OutW        = 15;
  localparam int unsigned MagW        = CosFracBits + 1;
  localparam int unsigned RadW        = 2 * CosFracBits + 1;
  localparam int unsigned ProdW       = FieldW + MagW;
  localparam int unsigned SumW        = ProdW + 1;
  localparam int unsigned SqW         = 2 * MagW;

  localparam logic [MagW-1:0]          One   = MagW'(1) << CosFracBits;
  localparam logic [RadW-1:0]          OneSq = RadW'(1) << (2 * CosFracBits);
  localparam logic signed [FieldW-1:0] OneS  = FieldW'(One);

  typedef struct packed {
    logic signed [FieldW-1:0] cos_term;
    logic [FieldW-1:0]        index_incident;
    logic [FieldW-1:0]        index_transmit;
  } in_t;

  typedef struct packed {
    logic [OutW-1:0] reflectance;
    logic            total_reflection;
  } out_t;

  // Indices after the side swap, cosine magnitude and forced-one flag
  typedef struct packed {
    logic [FieldW-1:0] n_i;
    logic [FieldW-1:0] n_t;
    logic [MagW-1:0]   c;
    logic              force_one;
  } geom_t;

  typedef struct packed {
    geom_t           geom;
    logic [RadW-1:0] rad;
  } rad_t;

  typedef struct packed {
    geom_t            geom;
    logic [ProdW-1:0] p;
  } snell_t;

  typedef struct packed {
    geom_t                  geom;
    logic [FieldW-1:0]      rem;
    logic [CosFracBits-1:0] low;
  } stdiv_t;

  typedef struct packed {
    logic [ProdW-1:0] a;
    logic [ProdW-1:0] b;
    logic [ProdW-1:0] d;
    logic [ProdW-1:0] e;
    logic             force_one;
  } prod_t;

  typedef struct packed {
    logic [1:0][SumW-1:0] num;
    logic [1:0][SumW-1:0] den;
    logic [1:0]           sat;
    logic                 force_one;
  } coef_t;

  typedef struct packed {
    logic [1:0] sat;
    logic       force_one;
  } cside_t;

  typedef struct packed {
    logic [SqW-1:0] sq_p;
    logic [SqW-1:0] sq_s;
    logic           force_one;
  } sq_t;

endpackage

// File: rtl/core/frd_stream_if.sv
interface frd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/fresnel_dielectric_reflectance.sv
// Unpolarized Fresnel reflectance of a dielectric boundary in fixed point.
// Cosine is Q2.14, reflectance unsigned Q1.14, indices unsigned Q4.12. A negative cosine
// swaps the indices; a zero transmitted index or total internal reflection
// returns one with total_reflection set. The datapath is a 66-stage pipeline:
// two 15-stage digit-by-digit square roots (incident sine, transmitted
// cosine), two 14-stage restoring dividers (transmitted sine, and both
// amplitude coefficients side by side) and eight single-stage multiply and
// compare steps. It takes one transaction per clock while the output is not
// stalled; an output stall backs up only as far as the nearest empty stage.
module fresnel_dielectric_reflectance
  import frd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  frd_stream_if.sink   in_i,
  frd_stream_if.source out_o
);

  // Front: clamp, side swap, 1 - c^2
  rad_t front_d, front_q;
  logic front_v, front_r;

  always_comb begin
    logic signed [FieldW-1:0] cl;
    cl = in_i.data.cos_term;
    if (cl > OneS) begin
      cl = OneS;
    end else if (cl < -OneS) begin
      cl = -OneS;
    end
    if (cl < 0) begin
      front_d.geom.n_i = in_i.data.index_transmit;
      front_d.geom.n_t = in_i.data.index_incident;
      front_d.geom.c   = MagW'(-cl);
    end else begin
      front_d.geom.n_i = in_i.data.index_incident;
      front_d.geom.n_t = in_i.data.index_transmit;
      front_d.geom.c   = MagW'(cl);
    end
    front_d.geom.force_one = in_i.data.index_transmit == '0;
    front_d.rad = OneSq - RadW'(RadW'(front_d.geom.c) * RadW'(front_d.geom.c));
  end

  frd_reg_stage #(.T(rad_t)) u_front (
    .clk_i, .rst_ni,
    .valid_i(in_i.valid), .ready_o(in_i.ready), .data_i(front_d),
    .valid_o(front_v), .ready_i(front_r), .data_o(front_q)
  );

  // Incident sine
  logic [MagW-1:0] si;
  geom_t           si_geom;
  logic            si_v, si_r;

  frd_isqrt #(.RW(RadW), .T(geom_t)) u_sqrt_si (
    .clk_i, .rst_ni,
    .valid_i(front_v), .ready_o(front_r), .rad_i(front_q.rad), .side_i(front_q.geom),
    .valid_o(si_v), .ready_i(si_r), .root_o(si), .side_o(si_geom)
  );

  snell_t snell_d, snell_q;
  logic   snell_v, snell_r;

  always_comb begin
    snell_d.geom = si_geom;
    snell_d.p    = ProdW'(si_geom.n_i) * ProdW'(si);
  end

  frd_reg_stage #(.T(snell_t)) u_snell (
    .clk_i, .rst_ni,
    .valid_i(si_v), .ready_o(si_r), .data_i(snell_d),
    .valid_o(snell_v), .ready_i(snell_r), .data_o(snell_q)
  );

  // Total internal reflection test; also catches a zero index after the swap
  stdiv_t tir_d, tir_q;
  logic   tir_v, tir_r;

  always_comb begin
    tir_d.geom           = snell_q.geom;
    tir_d.geom.force_one = snell_q.geom.force_one ||
                           (snell_q.p >= (ProdW'(snell_q.geom.n_t) << CosFracBits));
    tir_d.rem            = snell_q.p[CosFracBits +: FieldW];
    tir_d.low            = snell_q.p[CosFracBits-1:0];
  end

  frd_reg_stage #(.T(stdiv_t)) u_tir (
    .clk_i, .rst_ni,
    .valid_i(snell_v), .ready_o(snell_r), .data_i(tir_d),
    .valid_o(tir_v), .ready_i(tir_r), .data_o(tir_q)
  );

  // Transmitted sine
  logic [0:0][CosFracBits-1:0] st;
  geom_t                       st_geom;
  logic                        st_v, st_r;

  frd_div #(.DW(FieldW), .QB(CosFracBits), .LANES(1), .T(geom_t)) u_div_st (
    .clk_i, .rst_ni,
    .valid_i(tir_v), .ready_o(tir_r),
    .rem_i(tir_q.rem), .low_i(tir_q.low), .den_i(tir_q.geom.n_t), .side_i(tir_q.geom),
    .valid_o(st_v), .ready_i(st_r), .quot_o(st), .side_o(st_geom)
  );

  rad_t ctrad_d, ctrad_q;
  logic ctrad_v, ctrad_r;

  always_comb begin
    ctrad_d.geom = st_geom;
    ctrad_d.rad  = OneSq - RadW'(RadW'(st[0]) * RadW'(st[0]));
  end

  frd_reg_stage #(.T(rad_t)) u_ctrad (
    .clk_i, .rst_ni,
    .valid_i(st_v), .ready_o(st_r), .data_i(ctrad_d),
    .valid_o(ctrad_v), .ready_i(ctrad_r), .data_o(ctrad_q)
  );

  // Transmitted cosine
  logic [MagW-1:0] ct;
  geom_t           ct_geom;
  logic            ct_v, ct_r;

  frd_isqrt #(.RW(RadW), .T(geom_t)) u_sqrt_ct (
    .clk_i, .rst_ni,
    .valid_i(ctrad_v), .ready_o(ctrad_r), .rad_i(ctrad_q.rad), .side_i(ctrad_q.geom),
    .valid_o(ct_v), .ready_i(ct_r), .root_o(ct), .side_o(ct_geom)
  );

  prod_t prod_d, prod_q;
  logic  prod_v, prod_r;

  always_comb begin
    prod_d.a         = ProdW'(ct_geom.n_t) * ProdW'(ct_geom.c);
    prod_d.b         = ProdW'(ct_geom.n_i) * ProdW'(ct);
    prod_d.d         = ProdW'(ct_geom.n_i) * ProdW'(ct_geom.c);
    prod_d.e         = ProdW'(ct_geom.n_t) * ProdW'(ct);
    prod_d.force_one = ct_geom.force_one;
  end

  frd_reg_stage #(.T(prod_t)) u_prod (
    .clk_i, .rst_ni,
    .valid_i(ct_v), .ready_o(ct_r), .data_i(prod_d),
    .valid_o(prod_v), .ready_i(prod_r), .data_o(prod_q)
  );

  // Lane 0 parallel, lane 1 perpendicular
  coef_t coef_d, coef_q;
  logic  coef_v, coef_r;

  always_comb begin
    logic [SumW-1:0] x [2];
    logic [SumW-1:0] y [2];
    x[0] = SumW'(prod_q.a);
    y[0] = SumW'(prod_q.b);
    x[1] = SumW'(prod_q.d);
    y[1] = SumW'(prod_q.e);
    for (int l = 0; l < 2; l++) begin
      coef_d.num[l] = (x[l] >= y[l]) ? x[l] - y[l] : y[l] - x[l];
      coef_d.den[l] = x[l] + y[l];
      // Saturate to one, including a zero denominator
      coef_d.sat[l] = coef_d.num[l] >= coef_d.den[l];
    end
    coef_d.force_one = prod_q.force_one;
  end

  frd_reg_stage #(.T(coef_t)) u_coef (
    .clk_i, .rst_ni,
    .valid_i(prod_v), .ready_o(prod_r), .data_i(coef_d),
    .valid_o(coef_v), .ready_i(coef_r), .data_o(coef_q)
  );

  logic [1:0][SumW-1:0]        rdiv_rem;
  logic [1:0][CosFracBits-1:0] rquot;
  cside_t                      rdiv_side, rquot_side;
  logic                        rquot_v, rquot_r;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rdiv_rem[l] = coef_q.sat[l] ? '0 : coef_q.num[l];
    end
    rdiv_side.sat       = coef_q.sat;
    rdiv_side.force_one = coef_q.force_one;
  end

  frd_div #(.DW(SumW), .QB(CosFracBits), .LANES(2), .T(cside_t)) u_div_r (
    .clk_i, .rst_ni,
    .valid_i(coef_v), .ready_o(coef_r),
    .rem_i(rdiv_rem), .low_i('0), .den_i(coef_q.den), .side_i(rdiv_side),
    .valid_o(rquot_v), .ready_i(rquot_r), .quot_o(rquot), .side_o(rquot_side)
  );

  sq_t  sq_d, sq_q;
  logic sq_v, sq_r;

  always_comb begin
    logic [MagW-1:0] rp;
    logic [MagW-1:0] rs;
    rp = rquot_side.sat[0] ? One : MagW'(rquot[0]);
    rs = rquot_side.sat[1] ? One : MagW'(rquot[1]);
    sq_d.sq_p      = SqW'(rp) * SqW'(rp);
    sq_d.sq_s      = SqW'(rs) * SqW'(rs);
    sq_d.force_one = rquot_side.force_one;
  end

  frd_reg_stage #(.T(sq_t)) u_sq (
    .clk_i, .rst_ni,
    .valid_i(rquot_v), .ready_o(rquot_r), .data_i(sq_d),
    .valid_o(sq_v), .ready_i(sq_r), .data_o(sq_q)
  );

  out_t out_d;

  always_comb begin
    logic [SqW:0] sum;
    sum = (SqW + 1)'(sq_q.sq_p) + (SqW + 1)'(sq_q.sq_s);
    if (sq_q.force_one) begin
      out_d.reflectance = OutW'(One);
    end else begin
      out_d.reflectance = OutW'(sum >> (CosFracBits + 1));
    end
    out_d.total_reflection = sq_q.force_one;
  end

  frd_reg_stage #(.T(out_t)) u_out (
    .clk_i, .rst_ni,
    .valid_i(sq_v), .ready_o(sq_r), .data_i(out_d),
    .valid_o(out_o.valid), .ready_i(out_o.ready), .data_o(out_o.data)
  );

  a_flag_means_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.total_reflection |->
      out_o.data.reflectance == OutW'(One))
    else $error("total reflection with reflectance below one");

  a_refl_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.data.reflectance <= OutW'(One))
    else $error("reflectance above one");

  a_empty_out_takes_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("input stalled with empty output stage");

endmodule

// File: rtl/core/frd_reg_stage.sv
module frd_reg_stage #(
  parameter type T = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  T     data_i,
  output logic valid_o,
  input  logic ready_i,
  output T     data_o
);

  logic valid_q;
  T     data_q;

  // Take a new transaction when empty or when the current one leaves
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: rtl/core/frd_isqrt.sv
module frd_isqrt #(
  parameter int unsigned RW = 29,
  parameter type         T  = logic
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [RW-1:0]         rad_i,
  input  T                      side_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [(RW+1)/2-1:0]   root_o,
  output T                      side_o
);

  localparam int unsigned NS = (RW + 1) / 2;
  localparam int unsigned XW = RW + 1;

  logic [NS-1:0] v_q;
  logic [XW-1:0] x_q [NS];
  logic [XW-1:0] r_q [NS];
  T              side_q [NS];

  logic [NS-1:0] vin;
  logic [XW-1:0] xin [NS];
  logic [XW-1:0] rin [NS];
  T              sin [NS];
  logic [XW-1:0] x_d [NS];
  logic [XW-1:0] r_d [NS];
  logic [NS:0]   rdy;

  always_comb begin
    rdy[NS] = ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign ready_o = rdy[0];

  always_comb begin
    vin[0] = valid_i;
    xin[0] = XW'(rad_i);
    rin[0] = '0;
    sin[0] = side_i;
    for (int k = 1; k < NS; k++) begin
      vin[k] = v_q[k-1];
      xin[k] = x_q[k-1];
      rin[k] = r_q[k-1];
      sin[k] = side_q[k-1];
    end
  end

  // One root digit per stage, trial bit walks down by powers of four
  always_comb begin
    logic [XW-1:0] bitv;
    logic [XW-1:0] trial;
    for (int k = 0; k < NS; k++) begin
      bitv  = XW'(1) << (2 * (NS - 1 - k));
      trial = rin[k] + bitv;
      if (xin[k] >= trial) begin
        x_d[k] = xin[k] - trial;
        r_d[k] = (rin[k] >> 1) + bitv;
      end else begin
        x_d[k] = xin[k];
        r_d[k] = rin[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          v_q[k] <= vin[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      if (rdy[k] && vin[k]) begin
        x_q[k]    <= x_d[k];
        r_q[k]    <= r_d[k];
        side_q[k] <= sin[k];
      end
    end
  end

  assign valid_o = v_q[NS-1];
  assign root_o  = r_q[NS-1][NS-1:0];
  assign side_o  = side_q[NS-1];

endmodule

// File: rtl/core/frd_div.sv
module frd_div #(
  parameter int unsigned DW    = 16,
  parameter int unsigned QB    = 14,
  parameter int unsigned LANES = 1,
  parameter type         T     = logic
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [LANES-1:0][DW-1:0]   rem_i,
  input  logic [LANES-1:0][QB-1:0]   low_i,
  input  logic [LANES-1:0][DW-1:0]   den_i,
  input  T                           side_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [LANES-1:0][QB-1:0]   quot_o,
  output T                           side_o
);

  logic [QB-1:0]                 v_q;
  logic [LANES-1:0][DW-1:0]      rem_q  [QB];
  logic [LANES-1:0][QB-1:0]      low_q  [QB];
  logic [LANES-1:0][DW-1:0]      den_q  [QB];
  logic [LANES-1:0][QB-1:0]      quot_q [QB];
  T                              side_q [QB];

  logic [QB-1:0]                 vin;
  logic [LANES-1:0][DW-1:0]      remin  [QB];
  logic [LANES-1:0][QB-1:0]      lowin  [QB];
  logic [LANES-1:0][DW-1:0]      denin  [QB];
  logic [LANES-1:0][QB-1:0]      quotin [QB];
  T                              sin    [QB];
  logic [LANES-1:0][DW-1:0]      rem_d  [QB];
  logic [LANES-1:0][QB-1:0]      low_d  [QB];
  logic [LANES-1:0][QB-1:0]      quot_d [QB];
  logic [QB:0]                   rdy;

  always_comb begin
    rdy[QB] = ready_i;
    for (int k = QB - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign ready_o = rdy[0];

  always_comb begin
    vin[0]    = valid_i;
    remin[0]  = rem_i;
    lowin[0]  = low_i;
    denin[0]  = den_i;
    quotin[0] = '0;
    sin[0]    = side_i;
    for (int k = 1; k < QB; k++) begin
      vin[k]    = v_q[k-1];
      remin[k]  = rem_q[k-1];
      lowin[k]  = low_q[k-1];
      denin[k]  = den_q[k-1];
      quotin[k] = quot_q[k-1];
      sin[k]    = side_q[k-1];
    end
  end

  // Restoring step: shift in the next numerator bit, subtract if it fits
  always_comb begin
    logic [DW:0] trial;
    logic        fits;
    for (int k = 0; k < QB; k++) begin
      for (int l = 0; l < LANES; l++) begin
        trial = {remin[k][l], lowin[k][l][QB-1]};
        fits  = trial >= {1'b0, denin[k][l]};
        if (fits) begin
          rem_d[k][l] = DW'(trial - {1'b0, denin[k][l]});
        end else begin
          rem_d[k][l] = DW'(trial);
        end
        low_d[k][l]  = lowin[k][l] << 1;
        quot_d[k][l] = {quotin[k][l][QB-2:0], fits};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < QB; k++) begin
        if (rdy[k]) begin
          v_q[k] <= vin[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < QB; k++) begin
      if (rdy[k] && vin[k]) begin
        rem_q[k]  <= rem_d[k];
        low_q[k]  <= low_d[k];
        den_q[k]  <= denin[k];
        quot_q[k] <= quot_d[k];
        side_q[k] <= sin[k];
      end
    end
  end

  assign valid_o = v_q[QB-1];
  assign quot_o  = quot_q[QB-1];
  assign side_o  = side_q[QB-1];

endmodule
